FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertions on clk; SEM_ASSERT is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SEM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEM_ASSERT(lbl, prop, msg)
`define SEM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hdl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sem_pkg;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIX_W = 8;
  localparam int FW_W = 11;
  localparam int FH_W = 13;
  localparam int CFG_DW = 13;
  localparam int HEIGHT_MAX = 4096;
  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 13'd768;
  localparam logic [FH_W-1:0] ROW_SAT = 13'h1FFF;
  localparam int SQ_STEPS = 8;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } edge_mask_t;

  typedef logic signed [2:0] coef_t;
  localparam coef_t KX [3][3] = '{'{-3'sd1, 3'sd0, 3'sd1},
                                 '{-3'sd2, 3'sd0, 3'sd2},
                                 '{-3'sd1, 3'sd0, 3'sd1}};
  localparam coef_t KY [3][3] = '{'{-3'sd1, -3'sd2, -3'sd1},
                                 '{ 3'sd0,  3'sd0,  3'sd0},
                                 '{ 3'sd1,  3'sd2,  3'sd1}};
endpackage

FILE: hdl/sem_if.sv
// ----------------------------------------------------------------------------
// sem_if
// Valid/ready channel interfaces for pixels, results and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  modport source (output valid, mode, blue, green, red, input ready);
  modport sink   (input valid, mode, blue, green, red, output ready);
endinterface

interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_blue;
  logic [7:0] edge_green;
  logic [7:0] edge_red;
  logic       frame_end;
  modport source (output valid, edge_blue, edge_green, edge_red, frame_end, input ready);
  modport sink   (input valid, edge_blue, edge_green, edge_red, frame_end, output ready);
endinterface

interface sem_cfg_if;
  logic                          valid;
  logic                          ready;
  logic                          index;
  logic [sem_pkg::CFG_DW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/sem_lane.sv
// ----------------------------------------------------------------------------
// sem_lane
// One color lane: Sobel gradients, sum of squares, rounded square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sem_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sem_pkg::PIX_W-1:0]  pix [3][3],
  input  sem_pkg::edge_mask_t        mask,
  output logic                       done,
  output logic [sem_pkg::PIX_W-1:0]  mag
);
  logic signed [11:0] gx_r, gy_r, gx_c, gy_c;
  logic [21:0]        s_r;
  logic [7:0]         k_r;
  logic [3:0]         cnt_r;
  logic signed [23:0] gx2, gy2;
  logic [7:0]         cand;
  logic [15:0]        prod;
  logic [2:0]         bitpos;

  always_comb begin
    logic use_px;
    logic signed [11:0] p;
    gx_c = '0;
    gy_c = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        use_px = !((r == 0 && !mask.top) || (r == 2 && !mask.bottom) ||
                   (c == 0 && !mask.left) || (c == 2 && !mask.right));
        p = use_px ? $signed({4'b0, pix[r][c]}) : 12'sd0;
        gx_c = gx_c + p * 12'(sem_pkg::KX[r][c]);
        gy_c = gy_c + p * 12'(sem_pkg::KY[r][c]);
      end
    end
  end

  assign gx2 = 24'(gx_r) * 24'(gx_r);
  assign gy2 = 24'(gy_r) * 24'(gy_r);
  assign bitpos = 3'(4'd9 - cnt_r);
  assign cand = k_r | (8'd1 << bitpos);
  assign prod = 16'(cand) * 16'(cand - 8'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 4'd1;
    end else if (cnt_r == 4'd10) begin
      cnt_r <= '0;
    end else if (cnt_r != 4'd0) begin
      cnt_r <= cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gx_r <= gx_c;
      gy_r <= gy_c;
    end
    if (cnt_r == 4'd1) begin
      s_r <= 22'(gx2 + gy2);
      k_r <= '0;
    end else if (cnt_r >= 4'd2 && cnt_r <= 4'd9) begin
      if ({6'b0, prod} < s_r) begin
        k_r <= cand;
      end
    end
  end

  assign done = (cnt_r == 4'd10);
  assign mag  = k_r;
endmodule

FILE: hdl/sobel_edge_magnitude_rgb_top.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_top
// Streaming 3x3 Sobel edge magnitude over RGB pixels with three color lanes.
// ----------------------------------------------------------------------------
// Channels: in_ch carries raster-order pixels (mode 0) or flush items
// (mode 1); out_ch carries per-channel edge magnitudes and a frame_end flag;
// cfg_ch writes frame_width (index 0) and frame_height (index 1); the user
// must write them only while idle, which the block does not enforce. A result
// trails its pixel by frame_width+1 transactions; after the last pixel,
// flush transactions drain the remaining results; earlier flushes are dropped.
// Steps: a transaction that yields no result goes through accept and line
// store update; one that yields a result goes through accept, line store
// read and window shift, gradient sums, sum of squares, the bit-per-cycle
// rounded square root in each lane, and the merge into the output register.
// The square root iteration is the longest step; input is taken only in idle.
// The output register lets the next transaction enter while a result waits;
// a stalled receiver holds the block in the merge state until it drains.
// Reset clears counters, window, state, start and out valid; sets frame size.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sobel_edge_magnitude_rgb_top #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sem_in_if.sink     in_ch,
  sem_out_if.source  out_ch,
  sem_cfg_if.sink    cfg_ch
);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = AW + 1;
  localparam int FH = sem_pkg::FH_W;

  sem_pkg::state_t state_r, state_nxt;
  logic [sem_pkg::FW_W-1:0] frame_width_r;
  logic [FH-1:0]            frame_height_r;
  logic [23:0]              upper_mem [MAX_WIDTH];
  logic [23:0]              middle_mem [MAX_WIDTH];
  logic [23:0]              up_q_r, mid_q_r, pix_r;
  logic [23:0]              win_r [3][3];
  logic [AW-1:0]            in_col_r, out_col_r;
  logic [FH-1:0]            in_row_r;
  logic [FH-2:0]            out_row_r;
  logic                     emit_r, start_r;
  sem_pkg::edge_mask_t      mask_r;
  logic [CW-1:0]            eff_w;
  logic [FH-1:0]            eff_h;
  logic                     drain, accept, take, emit_go, in_last, out_last, fe;
  logic [2:0]               lane_done;
  logic [7:0]               lane_mag [3];
  logic [7:0]               lane_pix [3][3][3];
  logic                     out_valid_r, out_fe_r;
  logic [7:0]               out_mag_r [3];

  always_comb begin
    if (frame_width_r == '0) eff_w = CW'(1);
    else if (32'(frame_width_r) > 32'(MAX_WIDTH)) eff_w = CW'(MAX_WIDTH);
    else eff_w = CW'(frame_width_r);
    if (frame_height_r == '0) eff_h = FH'(1);
    else if (32'(frame_height_r) > 32'(sem_pkg::HEIGHT_MAX)) eff_h = FH'(sem_pkg::HEIGHT_MAX);
    else eff_h = frame_height_r;
  end

  assign drain    = in_row_r >= eff_h;
  assign in_ch.ready  = (state_r == sem_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign accept   = in_ch.valid && in_ch.ready;
  assign take     = accept && !(in_ch.mode && !drain);
  assign emit_go  = (state_r == sem_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign in_last  = (CW'(in_col_r) + CW'(1)) >= eff_w;
  assign out_last = (CW'(out_col_r) + CW'(1)) >= eff_w;
  assign fe       = out_last && ({1'b0, out_row_r} + FH'(1) >= eff_h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= sem_pkg::FW_RESET;
      frame_height_r <= sem_pkg::FH_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        sem_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_ch.data[sem_pkg::FW_W-1:0];
        sem_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sem_pkg::ST_IDLE: if (take) state_nxt = sem_pkg::ST_LOAD;
      sem_pkg::ST_LOAD: state_nxt = emit_r ? sem_pkg::ST_CALC : sem_pkg::ST_IDLE;
      sem_pkg::ST_CALC: if (lane_done[0]) state_nxt = sem_pkg::ST_EMIT;
      sem_pkg::ST_EMIT: if (emit_go) state_nxt = sem_pkg::ST_IDLE;
      default: state_nxt = sem_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sem_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    up_q_r  <= upper_mem[in_col_r];
    mid_q_r <= middle_mem[in_col_r];
    if (state_r == sem_pkg::ST_LOAD) begin
      upper_mem[in_col_r]  <= mid_q_r;
      middle_mem[in_col_r] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_r  <= drain ? 24'd0 : {in_ch.red, in_ch.green, in_ch.blue};
      emit_r <= (in_row_r >= FH'(2)) || (in_row_r == FH'(1) && in_col_r != '0);
    end
    if (state_r == sem_pkg::ST_LOAD) begin
      mask_r.top    <= out_row_r != '0;
      mask_r.bottom <= ({1'b0, out_row_r} + FH'(1)) < eff_h;
      mask_r.left   <= out_col_r != '0;
      mask_r.right  <= !out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win_r[r][c] <= '0;
      end
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      start_r   <= 1'b0;
    end else begin
      start_r <= (state_r == sem_pkg::ST_LOAD) && emit_r;
      if (state_r == sem_pkg::ST_LOAD) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= up_q_r;
        win_r[1][2] <= mid_q_r;
        win_r[2][2] <= pix_r;
        if (in_last) begin
          in_col_r <= '0;
          if (in_row_r != sem_pkg::ROW_SAT) in_row_r <= in_row_r + FH'(1);
        end else begin
          in_col_r <= in_col_r + AW'(1);
        end
      end
      if (emit_go) begin
        if (fe) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end else if (out_last) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + (FH-1)'(1);
        end else begin
          out_col_r <= out_col_r + AW'(1);
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) lane_pix[l][r][c] = win_r[r][c][8*l +: 8];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    sem_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (start_r),
      .pix   (lane_pix[l]),
      .mask  (mask_r),
      .done  (lane_done[l]),
      .mag   (lane_mag[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_mag_r <= lane_mag;
      out_fe_r  <= fe;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.edge_blue  = out_mag_r[0];
  assign out_ch.edge_green = out_mag_r[1];
  assign out_ch.edge_red   = out_mag_r[2];
  assign out_ch.frame_end  = out_fe_r;

  `SEM_ASSERT(a_lanes_lockstep, (lane_done == 3'b000 || lane_done == 3'b111), "lanes out of step")
  `SEM_ASSERT(a_done_in_calc, (lane_done[0] |-> state_r == sem_pkg::ST_CALC), "lane done outside calc")
  `SEM_ASSERT(a_load_from_emit, ($rose(out_valid_r) |-> $past(state_r) == sem_pkg::ST_EMIT), "result without merge")
  `SEM_ASSERT(a_frame_wrap, ((emit_go && fe) |=> (in_col_r == '0 && out_row_r == '0 && out_col_r == '0)), "frame end did not clear counters")
endmodule
